>>> sv/shelf_atlas_allocator_assert.svh
// Assertion macros for the shelf atlas allocator.
`ifndef SHELF_ATLAS_ALLOCATOR_ASSERT_SVH
`define SHELF_ATLAS_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SAA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SAA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/saa_pkg.sv
package saa_pkg;

  localparam int unsigned DIM_W           = 15;
  localparam int unsigned MAX_SHELVES_DEF = 64;

  // config register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] ATLAS_DIM_RST = 15'd128;
  localparam logic [DIM_W-1:0] FIRST_TOP     = 15'd3;
  localparam logic [DIM_W-1:0] FAIL_DIM      = 15'd2;

  // x / 10 == (x * 52429) >> 19, exact for x < 2^16
  localparam logic [15:0] TENTH_RECIP = 16'd52429;
  localparam int unsigned TENTH_SHIFT = 19;

  typedef struct packed {
    logic [DIM_W-1:0] glyph_width;
    logic [DIM_W-1:0] glyph_height;
  } req_t;

  typedef struct packed {
    logic [DIM_W-1:0] rect_left;
    logic [DIM_W-1:0] rect_top;
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
    logic             no_room;
  } rsp_t;

  typedef struct packed {
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] fill;
  } shelf_t;

endpackage

>>> sv/shelf_atlas_allocator.sv
// Channel   | Dir | Handshake                  | Payload
// ----------+-----+----------------------------+-----------------------------------
// in        | in  | in_valid_i / in_stall_o    | in_req_i  (glyph width, height)
// out       | out | out_valid_o / out_stall_i  | out_rsp_o (rect, no_room flag)
// cfg       | in  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One request at a time. An accepted request scans the shelf table from shelf 0
// upward and is placed on the first shelf that passes the test; one that fits no
// shelf opens a new shelf or fails. The next request is taken only once the result
// has moved into the output register. The scan is paced by the shelf table's single
// read port: one shelf is read and tested per cycle. Reset empties the table at once
// (shelf count zero, next top 3, atlas 128x128); no clearing pass. A finished result
// waits in the output register, and a new request is taken while it waits; the next
// result is held back until that register is free.
`include "shelf_atlas_allocator_assert.svh"

module shelf_atlas_allocator import saa_pkg::*; #(
  parameter int unsigned MAX_SHELVES = MAX_SHELVES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  req_t                 in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rsp_t                 out_rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  localparam int unsigned IW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int unsigned CW = $clog2(MAX_SHELVES + 1);
  localparam logic [CW-1:0] SHELF_LIMIT = CW'(MAX_SHELVES);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_NEW  = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]       state_q;
  logic [DIM_W-1:0] aw_q, ah_q;
  logic [CW-1:0]    count_q;
  logic [DIM_W-1:0] next_top_q;
  logic [CW-1:0]    issue_q;
  logic             chk_v_q;
  logic [IW-1:0]    chk_idx_q;
  logic             out_valid_q;

  // request payload, held for the whole scan
  logic [DIM_W-1:0] w_q, h_q;
  logic [18:0]      h10_q;
  logic [15:0]      nh_q;
  rsp_t             res_q;
  rsp_t             out_q;

  // shelf table
  shelf_t           mem [MAX_SHELVES];
  shelf_t           rd_q;

  logic in_acc, out_free, resp_load;
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign resp_load   = (state_q == ST_RESP) && out_free;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // new shelf height h + h/10, by reciprocal multiply
  logic [30:0] tenth_prod;
  logic [11:0] h_div10;
  logic [15:0] nh_d;
  assign tenth_prod = 31'(in_req_i.glyph_height) * 31'(TENTH_RECIP);
  assign h_div10    = tenth_prod[30:TENTH_SHIFT];
  assign nh_d       = 16'(in_req_i.glyph_height) + 16'(h_div10);

  // shelf test on the entry read last cycle: 10h >= 7H, h <= H, fill + w <= width
  logic [18:0] sh7;
  logic [15:0] fill_sum;
  logic        hit;
  assign sh7      = (19'(rd_q.height) << 3) - 19'(rd_q.height);
  assign fill_sum = 16'(rd_q.fill) + 16'(w_q);
  assign hit      = (h10_q >= sh7) && (h_q <= rd_q.height) && (fill_sum <= 16'(aw_q));

  logic [16:0] new_bottom;
  logic        fail;
  assign new_bottom = 17'(next_top_q) + 17'(nh_q);
  assign fail = (new_bottom >= 17'(ah_q)) || (w_q >= aw_q) || (count_q >= SHELF_LIMIT);

  logic scan_hit, more;
  assign scan_hit = (state_q == ST_SCAN) && chk_v_q && hit;
  assign more     = issue_q < count_q;

  // one write port, one registered read port
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_wa;
  shelf_t        mem_wd;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = chk_idx_q;
    mem_wd = rd_q;
    if (scan_hit) begin
      mem_we      = 1'b1;
      mem_wd.fill = fill_sum[DIM_W-1:0];
    end else if ((state_q == ST_NEW) && !fail) begin
      mem_we = 1'b1;
      mem_wa = count_q[IW-1:0];
      mem_wd = '{top: next_top_q, height: nh_q[DIM_W-1:0], fill: w_q};
    end
  end
  assign mem_re = (state_q == ST_SCAN) && more && !(chk_v_q && hit);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[issue_q[IW-1:0]];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      aw_q        <= ATLAS_DIM_RST;
      ah_q        <= ATLAS_DIM_RST;
      count_q     <= '0;
      next_top_q  <= FIRST_TOP;
      issue_q     <= '0;
      chk_v_q     <= 1'b0;
      chk_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ATLAS_WIDTH:  aw_q <= cfg_data_i;
          CFG_ATLAS_HEIGHT: ah_q <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            issue_q <= '0;
            chk_v_q <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chk_v_q && hit) begin
            chk_v_q <= 1'b0;
            state_q <= ST_RESP;
          end else if (more) begin
            chk_v_q   <= 1'b1;
            chk_idx_q <= issue_q[IW-1:0];
            issue_q   <= issue_q + 1'b1;
          end else if (chk_v_q) begin
            chk_v_q <= 1'b0;   // drain last tested entry
          end else begin
            state_q <= ST_NEW;
          end
        end
        ST_NEW: begin
          if (!fail) begin
            count_q    <= count_q + 1'b1;
            next_top_q <= new_bottom[DIM_W-1:0];
          end
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (resp_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      w_q   <= in_req_i.glyph_width;
      h_q   <= in_req_i.glyph_height;
      h10_q <= (19'(in_req_i.glyph_height) << 3) + (19'(in_req_i.glyph_height) << 1);
      nh_q  <= nh_d;
    end
    if (scan_hit) begin
      res_q <= '{rect_left: rd_q.fill, rect_top: rd_q.top,
                 rect_width: w_q, rect_height: h_q, no_room: 1'b0};
    end else if (state_q == ST_NEW) begin
      if (fail) begin
        res_q <= '{rect_left: '0, rect_top: '0,
                   rect_width: FAIL_DIM, rect_height: FAIL_DIM, no_room: 1'b1};
      end else begin
        res_q <= '{rect_left: '0, rect_top: next_top_q,
                   rect_width: w_q, rect_height: h_q, no_room: 1'b0};
      end
    end
    if (resp_load) begin
      out_q <= res_q;
    end
  end

  // checks
  `SAA_ASSERT_NEXT(a_accept_starts_scan, in_acc, (state_q == ST_SCAN) && (issue_q == '0) && !chk_v_q, "accepted request did not start a scan from shelf 0")
  `SAA_ASSERT_NEXT(a_new_shelf_count, (state_q == ST_NEW) && !fail, count_q == $past(count_q) + 1'b1, "opened shelf not counted")
  `SAA_ASSERT_NOW(a_result_from_resp, $rose(out_valid_q), $past(state_q) == ST_RESP, "result raised outside the response step")
  `SAA_ASSERT_NOW(a_count_limit, 1'b1, count_q <= SHELF_LIMIT, "shelf count beyond table size")

endmodule
